/* design/tmgq_pkg.sv */
// package for the tone map / gamma / quantize block
// holds fixed-point widths, pipeline depth and the gamma threshold table
// no dependencies
package tmgq_pkg;

  localparam int InFracBits  = 16;
  localparam int MapFracBits = 16;
  localparam int PixW        = 24;
  localparam int ByteW       = 8;
  localparam int SqW         = 2 * PixW;
  localparam int DivW        = 62;
  localparam int QW          = MapFracBits + 1;
  localparam int NumThr      = 1 << ByteW;
  // multiply, form ratio terms, integer bit, fraction bits, two gamma steps
  localparam int LaneLat     = 3 + MapFracBits + 2;
  localparam int WideW       = 200;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [QW-1:0]    q_t;
  typedef q_t               thr_t [NumThr];

  // smallest q with q^5 * 2^88 >= k^11 * 2^(5*MapFracBits)
  function automatic thr_t build_thresholds();
    thr_t                 t;
    logic [WideW-1:0]     kp;
    logic [WideW-1:0]     qp;
    logic [WideW-1:0]     rhs;
    logic [QW:0]          lo;
    logic [QW:0]          hi;
    logic [QW:0]          mid;
    int                   sh;
    t[0] = '0;
    sh = 5 * MapFracBits - 88;
    for (int k = 1; k < NumThr; k++) begin
      kp = WideW'(1);
      for (int i = 0; i < 11; i++) begin
        kp = kp * WideW'(k);
      end
      rhs = (sh >= 0) ? (kp << sh) : kp;
      lo = '0;
      hi = (QW+1)'(1) << MapFracBits;
      for (int it = 0; it < QW + 2; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          qp = WideW'(1);
          for (int i = 0; i < 5; i++) begin
            qp = qp * WideW'(mid);
          end
          qp = (sh >= 0) ? qp : (qp << (-sh));
          if (qp >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + 1'b1;
          end
        end
      end
      t[k] = lo[QW-1:0];
    end
    return t;
  endfunction

  localparam thr_t GammaThr = build_thresholds();

endpackage

/* design/tmgq_pix_if.sv */
// channel interfaces: linear pixel in, display bytes out
// depends on tmgq_pkg
interface tmgq_pix_if;
  logic              valid;
  logic              ready;
  tmgq_pkg::pix_t    red_in;
  tmgq_pkg::pix_t    green_in;
  tmgq_pkg::pix_t    blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface tmgq_byte_if;
  logic              valid;
  logic              ready;
  tmgq_pkg::byte_t   red_byte;
  tmgq_pkg::byte_t   green_byte;
  tmgq_pkg::byte_t   blue_byte;
  modport source (output valid, red_byte, green_byte, blue_byte, input ready);
  modport sink   (input valid, red_byte, green_byte, blue_byte, output ready);
endinterface

/* design/tmgq_lane.sv */
// one color lane: square, ratio terms, pipelined restoring divider, gamma search
// depends on tmgq_pkg
module tmgq_lane (
  input  logic            clk_i,
  input  logic            en_i,
  input  tmgq_pkg::pix_t  x_i,
  output tmgq_pkg::byte_t byte_o
);
  import tmgq_pkg::*;

  logic [SqW-1:0]  sq_q;
  pix_t            x_q;
  logic [DivW-1:0] num_q, den_q;
  logic [DivW-1:0] rem_q [MapFracBits+1];
  logic [DivW-1:0] dv_q  [MapFracBits+1];
  q_t              quo_q [MapFracBits+1];
  q_t              qa_q;
  byte_t           ka_d, ka_q, kb_d, kb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= x_i * x_i;
      x_q   <= x_i;
      num_q <= DivW'(sq_q) * DivW'(2259) + ((DivW'(x_q) * DivW'(45)) << InFracBits);
      den_q <= DivW'(sq_q) * DivW'(2187) + ((DivW'(x_q) * DivW'(885)) << InFracBits)
             + (DivW'(350) << (2 * InFracBits));
      // ratio is below two, so the integer part is one bit
      if (num_q >= den_q) begin
        rem_q[0] <= num_q - den_q;
        quo_q[0] <= q_t'(1);
      end else begin
        rem_q[0] <= num_q;
        quo_q[0] <= '0;
      end
      dv_q[0] <= den_q;
    end
  end

  for (genvar s = 1; s <= MapFracBits; s++) begin : g_div
    logic [DivW:0] sh;
    logic          ge;
    assign sh = {rem_q[s-1], 1'b0};
    assign ge = sh >= {1'b0, dv_q[s-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DivW'(sh - {1'b0, dv_q[s-1]}) : DivW'(sh);
        dv_q[s]  <= dv_q[s-1];
        quo_q[s] <= {quo_q[s-1][QW-2:0], ge};
      end
    end
  end

  // binary search over the monotone threshold table, four bits per stage
  always_comb begin
    byte_t cand;
    ka_d = '0;
    for (int b = ByteW - 1; b >= ByteW / 2; b--) begin
      cand = ka_d | (byte_t'(1) << b);
      if (quo_q[MapFracBits] >= GammaThr[cand]) ka_d = cand;
    end
  end

  always_comb begin
    byte_t cand;
    kb_d = ka_q;
    for (int b = ByteW / 2 - 1; b >= 0; b--) begin
      cand = kb_d | (byte_t'(1) << b);
      if (qa_q >= GammaThr[cand]) kb_d = cand;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ka_q <= ka_d;
      qa_q <= quo_q[MapFracBits];
      kb_q <= kb_d;
    end
  end

  assign byte_o = kb_q;
endmodule

/* design/aces_tonemap_gamma_quantize_top.sv */
// each result passes the lane pipeline, then the output register
// throughput: one pixel per cycle unless the output stalls; three color lanes in parallel
// the whole pipeline holds while a result waits; input ready follows output space
// reset: asynchronous active low, clears valid bits only; no other state
// depends on tmgq_pkg, tmgq_pix_if, tmgq_byte_if, tmgq_lane
module aces_tonemap_gamma_quantize_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  tmgq_pix_if.sink    in_i,
  tmgq_byte_if.source out_o
);
  import tmgq_pkg::*;

  logic              en;
  logic [LaneLat-1:0] vld_q;
  logic              out_vld_q;
  byte_t             r_b, g_b, b_b;
  byte_t             r_q, g_q, b_q;

  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  tmgq_lane u_red   (.clk_i(clk_i), .en_i(en), .x_i(in_i.red_in),   .byte_o(r_b));
  tmgq_lane u_green (.clk_i(clk_i), .en_i(en), .x_i(in_i.green_in), .byte_o(g_b));
  tmgq_lane u_blue  (.clk_i(clk_i), .en_i(en), .x_i(in_i.blue_in),  .byte_o(b_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LaneLat-2:0], in_i.valid};
      out_vld_q <= vld_q[LaneLat-1];
    end
  end

  // merge the three lanes into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= r_b;
      g_q <= g_b;
      b_q <= b_b;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.red_byte   = r_q;
  assign out_o.green_byte = g_q;
  assign out_o.blue_byte  = b_q;
endmodule

/* design/tmgq_checker.sv */
// port-level checks for the tone map top level, bound to it below
// depends on tmgq_pkg and aces_tonemap_gamma_quantize_top
module tmgq_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input tmgq_pkg::byte_t red_i,
  input tmgq_pkg::byte_t green_i,
  input tmgq_pkg::byte_t blue_i
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_i)
      && $stable(green_i) && $stable(blue_i))
    else $error("stalled result changed");

  // input side has room exactly when the output register does
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready mismatch");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  // a free pipeline never produces a result out of nothing right after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result right after reset");
endmodule

bind aces_tonemap_gamma_quantize_top tmgq_checker u_tmgq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .red_i      (out_o.red_byte),
  .green_i    (out_o.green_byte),
  .blue_i     (out_o.blue_byte)
);
